### rtl/core/csseg_pkg.sv
// Shared constants, command and register codes for the colour sphere segmenter.
// Holds the controller-to-datapath command and status structures.
// No dependencies.
package csseg_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 8;
  localparam int CHAN_W     = 8;
  localparam int CNT_W      = 24;
  localparam int SUM_W      = CNT_W + CHAN_W;
  localparam int MEAN_W     = CHAN_W + FRAC_BITS;
  localparam int NUM_W      = SUM_W + FRAC_BITS;
  localparam int PROD_W     = 2 * MEAN_W;
  localparam int DIST_W     = PROD_W + 2;
  localparam int BIT_CNT_W  = $clog2(MEAN_W);
  localparam int NUM_CH     = 3;
  localparam int CH_W       = 2;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = COORD_BITS;

  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [CHAN_W-1:0] MASK_ON   = 8'd255;
  localparam logic [CHAN_W-1:0] MASK_OFF  = 8'd0;

  localparam logic [CMD_W-1:0] CMD_LEARN    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CORNER_A_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_A_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_B_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_B_Y = 2'd3;

  typedef struct packed {
    logic            learn_en;
    logic            clear_en;
    logic            pix_load;
    logic            div_load;
    logic            div_step;
    logic            div_store;
    logic [CH_W-1:0] ch;
    logic            sq_load;
    logic            src_max;
    logic            acc_first;
    logic            acc_add;
    logic            rad_load;
    logic            out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic stats_ready;
    logic count_zero;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/core/csseg_dp.sv
// Datapath of the colour sphere segmenter: corner registers, learn accumulators,
// shared restoring divider, shared squaring unit and the output register.
// Depends on csseg_pkg.
module csseg_dp import csseg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [COORD_BITS-1:0] pixel_col,
  input  logic [COORD_BITS-1:0] pixel_row,
  input  logic [CHAN_W-1:0]     chan_first,
  input  logic [CHAN_W-1:0]     chan_second,
  input  logic [CHAN_W-1:0]     chan_third,
  input  dp_cmd_t               ctl,
  output dp_status_t            sts,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [CHAN_W-1:0]     mask_value,
  output logic                  region_empty
);

  logic [COORD_BITS-1:0] corner_a_x, corner_a_y, corner_b_x, corner_b_y;
  logic [COORD_BITS-1:0] x_lo, x_hi, y_lo, y_hi;
  logic                  in_rect, learn_take;

  logic [CNT_W-1:0]  sample_count;
  logic [SUM_W-1:0]  channel_sums   [NUM_CH];
  logic [CHAN_W-1:0] channel_maxima [NUM_CH];
  logic [MEAN_W-1:0] mean_colour    [NUM_CH];
  logic [DIST_W-1:0] radius_squared;
  logic              stats_ready;
  logic [CHAN_W-1:0] pix_in [NUM_CH];
  logic [CHAN_W-1:0] pix    [NUM_CH];

  logic [NUM_W-1:0]  num;
  logic [CNT_W-1:0]  rem;
  logic [MEAN_W-1:0] low;
  logic [MEAN_W-1:0] quot;
  logic [CNT_W:0]    trial;
  logic              trial_ge;

  logic [CHAN_W-1:0] sq_val;
  logic [MEAN_W-1:0] scaled, diff;
  logic [PROD_W-1:0] prod;
  logic [DIST_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_a_x <= '0;
      corner_a_y <= '0;
      corner_b_x <= '0;
      corner_b_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CORNER_A_X: corner_a_x <= cfg_data;
        REG_CORNER_A_Y: corner_a_y <= cfg_data;
        REG_CORNER_B_X: corner_b_x <= cfg_data;
        REG_CORNER_B_Y: corner_b_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // The rectangle includes its lower edges and excludes its upper edges.
  assign x_lo = (corner_a_x < corner_b_x) ? corner_a_x : corner_b_x;
  assign x_hi = (corner_a_x < corner_b_x) ? corner_b_x : corner_a_x;
  assign y_lo = (corner_a_y < corner_b_y) ? corner_a_y : corner_b_y;
  assign y_hi = (corner_a_y < corner_b_y) ? corner_b_y : corner_a_y;
  assign in_rect = (pixel_col >= x_lo) && (pixel_col < x_hi) &&
                   (pixel_row >= y_lo) && (pixel_row < y_hi);
  assign learn_take = ctl.learn_en && in_rect && (sample_count != COUNT_MAX);

  assign pix_in[0] = chan_first;
  assign pix_in[1] = chan_second;
  assign pix_in[2] = chan_third;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear_en) begin
      sample_count   <= '0;
      radius_squared <= '0;
      stats_ready    <= 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
        channel_sums[c]   <= '0;
        channel_maxima[c] <= '0;
        mean_colour[c]    <= '0;
      end
    end else begin
      if (learn_take) begin
        sample_count <= sample_count + CNT_W'(1);
        stats_ready  <= 1'b0;
        for (int c = 0; c < NUM_CH; c++) begin
          channel_sums[c] <= channel_sums[c] + SUM_W'(pix_in[c]);
          if (pix_in[c] > channel_maxima[c]) begin
            channel_maxima[c] <= pix_in[c];
          end
        end
      end
      if (ctl.div_store) begin
        mean_colour[ctl.ch] <= quot;
      end
      if (ctl.rad_load) begin
        radius_squared <= acc;
        stats_ready    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pix_load) begin
      for (int c = 0; c < NUM_CH; c++) begin
        pix[c] <= pix_in[c];
      end
    end
  end

  // Rounded mean: (sum * 2^FRAC_BITS + count/2) / count, one quotient bit a cycle.
  // The quotient fits MEAN_W bits, so the top part of the numerator starts
  // below the divisor and serves as the first partial remainder.
  assign num      = {channel_sums[ctl.ch], {FRAC_BITS{1'b0}}} + NUM_W'(sample_count >> 1);
  assign trial    = {rem, low[MEAN_W-1]};
  assign trial_ge = trial >= {1'b0, sample_count};

  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      rem <= num[NUM_W-1:MEAN_W];
      low <= num[MEAN_W-1:0];
    end else if (ctl.div_step) begin
      rem  <= trial_ge ? CNT_W'(trial - {1'b0, sample_count}) : trial[CNT_W-1:0];
      low  <= {low[MEAN_W-2:0], 1'b0};
      quot <= {quot[MEAN_W-2:0], trial_ge};
    end
  end

  // One channel is squared per cycle; each product is added to the sum in the next cycle.
  assign sq_val = ctl.src_max ? channel_maxima[ctl.ch] : pix[ctl.ch];
  assign scaled = {sq_val, {FRAC_BITS{1'b0}}};
  assign diff   = (scaled >= mean_colour[ctl.ch]) ? scaled - mean_colour[ctl.ch]
                                                  : mean_colour[ctl.ch] - scaled;

  always_ff @(posedge clk) begin
    if (ctl.sq_load) begin
      prod <= PROD_W'(diff) * PROD_W'(diff);
    end
    if (ctl.acc_first) begin
      acc <= DIST_W'(prod);
    end else if (ctl.acc_add) begin
      acc <= acc + DIST_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      region_empty <= (sample_count == '0);
      mask_value   <= ((sample_count != '0) && (acc <= radius_squared)) ? MASK_ON : MASK_OFF;
    end
  end

  assign sts.stats_ready = stats_ready;
  assign sts.count_zero  = (sample_count == '0);
  assign sts.out_free    = !out_valid || !out_stall;

endmodule

### rtl/core/csseg_ctrl.sv
// Controller of the colour sphere segmenter: input handshake and the sequence
// of divider, squaring and result steps issued to the datapath.
// Depends on csseg_pkg.
module csseg_ctrl import csseg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] cmd,
  input  dp_status_t       sts,
  output dp_cmd_t          ctl
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DLOAD,
    ST_DSTEP,
    ST_DSTORE,
    ST_SQ,
    ST_RSTORE,
    ST_RESULT
  } state_t;

  state_t               state;
  logic [CH_W-1:0]      ch;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [1:0]           step;
  logic                 for_radius;
  logic                 accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ch         <= '0;
      bit_cnt    <= '0;
      step       <= '0;
      for_radius <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && (cmd == CMD_CLASSIFY)) begin
            ch   <= '0;
            step <= '0;
            if (sts.count_zero) begin
              state <= ST_RESULT;
            end else if (!sts.stats_ready) begin
              for_radius <= 1'b1;
              state      <= ST_DLOAD;
            end else begin
              for_radius <= 1'b0;
              state      <= ST_SQ;
            end
          end
        end
        ST_DLOAD: begin
          bit_cnt <= '0;
          state   <= ST_DSTEP;
        end
        ST_DSTEP: begin
          if (bit_cnt == BIT_CNT_W'(MEAN_W - 1)) begin
            state <= ST_DSTORE;
          end else begin
            bit_cnt <= bit_cnt + BIT_CNT_W'(1);
          end
        end
        ST_DSTORE: begin
          if (ch == CH_W'(NUM_CH - 1)) begin
            ch    <= '0;
            step  <= '0;
            state <= ST_SQ;
          end else begin
            ch    <= ch + CH_W'(1);
            state <= ST_DLOAD;
          end
        end
        ST_SQ: begin
          if (step == 2'd3) begin
            step  <= '0;
            state <= for_radius ? ST_RSTORE : ST_RESULT;
          end else begin
            step <= step + 2'd1;
          end
        end
        ST_RSTORE: begin
          for_radius <= 1'b0;
          state      <= ST_SQ;
        end
        ST_RESULT: begin
          if (sts.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    ctl.learn_en  = accept && (cmd == CMD_LEARN);
    ctl.clear_en  = accept && (cmd == CMD_CLEAR);
    ctl.pix_load  = accept && (cmd == CMD_CLASSIFY);
    ctl.div_load  = (state == ST_DLOAD);
    ctl.div_step  = (state == ST_DSTEP);
    ctl.div_store = (state == ST_DSTORE);
    ctl.ch        = (state == ST_SQ) ? step : ch;
    ctl.sq_load   = (state == ST_SQ) && (step != 2'd3);
    ctl.src_max   = for_radius;
    ctl.acc_first = (state == ST_SQ) && (step == 2'd1);
    ctl.acc_add   = (state == ST_SQ) && ((step == 2'd2) || (step == 2'd3));
    ctl.rad_load  = (state == ST_RSTORE);
    ctl.out_load  = (state == ST_RESULT) && sts.out_free;
  end

`ifndef SYNTH
  a_radius_marks_ready: assert property (@(posedge clk) disable iff (rst)
    ctl.rad_load |=> sts.stats_ready)
    else $error("radius stored without statistics becoming ready");

  a_divide_full_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DSTORE) |-> (bit_cnt == BIT_CNT_W'(MEAN_W - 1)))
    else $error("quotient stored before all bits were produced");

  a_radius_needs_samples: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SQ) && for_radius) |-> !sts.count_zero)
    else $error("radius computed for an empty region");

  a_single_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.learn_en, ctl.clear_en, ctl.pix_load, ctl.div_load,
              ctl.div_step, ctl.div_store, ctl.rad_load, ctl.out_load}))
    else $error("conflicting datapath commands");
`endif

endmodule

### rtl/core/color_sphere_segmenter.sv
// Colour sphere segmenter, top level. Learn and clear words do not stall the input.
// A classify word with current statistics runs the squaring steps, then waits in the
// result state until the output is free; the input stalls until it is back in idle.
// After learning, the first classify word first computes each 8.8 channel mean
// with the shared one-bit-per-cycle divider and the radius with the squaring unit.
// Synchronous active-high reset clears the corners, all statistics and out_valid.
module color_sphere_segmenter import csseg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [COORD_BITS-1:0] pixel_col,
  input  logic [COORD_BITS-1:0] pixel_row,
  input  logic [CHAN_W-1:0]     chan_first,
  input  logic [CHAN_W-1:0]     chan_second,
  input  logic [CHAN_W-1:0]     chan_third,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAN_W-1:0]     mask_value,
  output logic                  region_empty
);

  dp_cmd_t    ctl;
  dp_status_t sts;

  csseg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts),
    .ctl      (ctl)
  );

  csseg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_col    (pixel_col),
    .pixel_row    (pixel_row),
    .chan_first   (chan_first),
    .chan_second  (chan_second),
    .chan_third   (chan_third),
    .ctl          (ctl),
    .sts          (sts),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .mask_value   (mask_value),
    .region_empty (region_empty)
  );

endmodule
